>>> rtl/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg: shared types and constants of the double-ended queue
// Opcodes, result status codes, and the command that the front part hands to
// the back part through the command queue.
// ----------------------------------------------------------------------------
package deq_pkg;

  // Largest ring size the command format can address
  localparam int MAX_CAPACITY = 64;
  localparam int ADDR_W       = $clog2(MAX_CAPACITY);
  localparam int DATA_W       = 32;

  // Stream payload and sideband widths
  localparam int IN_TDATA_W   = 32;
  localparam int IN_TUSER_W   = 3;
  localparam int OUT_TDATA_W  = 32;
  localparam int OUT_TUSER_W  = 2;

  // Command queue between front and back
  localparam int CMDQ_DEPTH   = 4;
  localparam int CMDQ_PTR_W   = $clog2(CMDQ_DEPTH);

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_LIST_FWD   = 3'd4,
    OP_LIST_BWD   = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // What the back part does with one command
  typedef enum logic [1:0] {
    CMD_PASS  = 2'd0,  // emit the carried value, no store access
    CMD_WRITE = 2'd1,  // write the value to the store and emit it
    CMD_READ  = 2'd2   // read the store and emit the entry
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [ADDR_W-1:0]  addr;
    logic [DATA_W-1:0]  value;
    status_t            status;
    logic               last;
  } cmd_t;

endpackage

>>> rtl/deq_cmdq.sv
// ----------------------------------------------------------------------------
// deq_cmdq: command queue between front and back
// Small register FIFO that lets the front part and the back part stall
// independently of each other.
// ----------------------------------------------------------------------------
module deq_cmdq (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  deq_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output deq_pkg::cmd_t head_cmd
);

  deq_pkg::cmd_t                   slots [deq_pkg::CMDQ_DEPTH];
  logic [deq_pkg::CMDQ_PTR_W-1:0]  wr_ptr;
  logic [deq_pkg::CMDQ_PTR_W-1:0]  rd_ptr;
  logic [deq_pkg::CMDQ_PTR_W:0]    fill;

  assign full       = (fill == (deq_pkg::CMDQ_PTR_W+1)'(deq_pkg::CMDQ_DEPTH));
  assign head_valid = (fill != '0);
  assign head_cmd   = slots[rd_ptr];

  // Store pushed commands
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

>>> rtl/deq_front.sv
// ----------------------------------------------------------------------------
// deq_front: request decode and queue bookkeeping
// Accepts requests, keeps the front index and entry count, and turns each
// request into store commands. A listing expands into one read per entry.
// ----------------------------------------------------------------------------
module deq_front #(
  parameter int CAPACITY = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_ready,
  input  logic [2:0]                  opcode,
  input  logic [deq_pkg::DATA_W-1:0]  value,
  output logic                        cmd_push,
  output deq_pkg::cmd_t               cmd,
  input  logic                        cmdq_full
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    FR_IDLE = 2'b01,
    FR_LIST = 2'b10
  } fr_state_t;

  fr_state_t         state, state_next;
  logic [IDX_W-1:0]  front_index, front_index_next;
  logic [CNT_W-1:0]  entry_count, entry_count_next;
  logic [IDX_W-1:0]  list_pos, list_pos_next;
  logic [CNT_W-1:0]  list_left, list_left_next;
  logic              list_bwd, list_bwd_next;

  logic              accept;
  logic              is_full;
  logic              is_empty;
  logic [IDX_W-1:0]  tail_pos;
  logic [IDX_W-1:0]  back_pos;
  logic [IDX_W-1:0]  front_dec;
  logic [IDX_W-1:0]  front_inc;
  deq_pkg::op_t      op;

  // Ring position of front + k, with k below CAPACITY
  function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                input logic [CNT_W-1:0] k);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(base) + (CNT_W+1)'(k);
    if (sum >= (CNT_W+1)'(CAPACITY)) begin
      sum = sum - (CNT_W+1)'(CAPACITY);
    end
    return sum[IDX_W-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] ring_inc(input logic [IDX_W-1:0] p);
    return (p == IDX_W'(CAPACITY - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] ring_dec(input logic [IDX_W-1:0] p);
    return (p == '0) ? IDX_W'(CAPACITY - 1) : p - 1'b1;
  endfunction

  assign op        = deq_pkg::op_t'(opcode);
  assign req_ready = (state == FR_IDLE) && !cmdq_full;
  assign accept    = req_valid && req_ready;
  assign is_full   = (entry_count == CNT_W'(CAPACITY));
  assign is_empty  = (entry_count == '0);
  assign tail_pos  = ring_add(front_index, entry_count);
  assign back_pos  = ring_add(front_index, entry_count - 1'b1);
  assign front_dec = ring_dec(front_index);
  assign front_inc = ring_inc(front_index);

  // Decode requests and step the listing
  always_comb begin
    state_next       = state;
    front_index_next = front_index;
    entry_count_next = entry_count;
    list_pos_next    = list_pos;
    list_left_next   = list_left;
    list_bwd_next    = list_bwd;
    cmd_push         = 1'b0;
    cmd.kind         = deq_pkg::CMD_PASS;
    cmd.addr         = '0;
    cmd.value        = '0;
    cmd.status       = deq_pkg::ST_OK;
    cmd.last         = 1'b1;

    unique case (state)
      FR_IDLE: begin
        if (accept) begin
          unique case (op)
            deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_PUSH_BACK: begin
              cmd_push = 1'b1;
              if (is_full) begin
                cmd.status = deq_pkg::ST_FULL;
              end else begin
                cmd.kind         = deq_pkg::CMD_WRITE;
                cmd.value        = value;
                entry_count_next = entry_count + 1'b1;
                if (op == deq_pkg::OP_PUSH_FRONT) begin
                  cmd.addr         = deq_pkg::ADDR_W'(front_dec);
                  front_index_next = front_dec;
                end else begin
                  cmd.addr = deq_pkg::ADDR_W'(tail_pos);
                end
              end
            end
            deq_pkg::OP_POP_FRONT, deq_pkg::OP_POP_BACK: begin
              cmd_push = 1'b1;
              if (is_empty) begin
                cmd.status = deq_pkg::ST_EMPTY;
              end else begin
                cmd.kind         = deq_pkg::CMD_READ;
                entry_count_next = entry_count - 1'b1;
                if (op == deq_pkg::OP_POP_FRONT) begin
                  cmd.addr         = deq_pkg::ADDR_W'(front_index);
                  front_index_next = front_inc;
                end else begin
                  cmd.addr = deq_pkg::ADDR_W'(back_pos);
                end
              end
            end
            deq_pkg::OP_LIST_FWD, deq_pkg::OP_LIST_BWD: begin
              if (is_empty) begin
                cmd_push   = 1'b1;
                cmd.status = deq_pkg::ST_EMPTY;
              end else begin
                state_next     = FR_LIST;
                list_left_next = entry_count;
                list_bwd_next  = (op == deq_pkg::OP_LIST_BWD);
                list_pos_next  = (op == deq_pkg::OP_LIST_BWD) ? back_pos : front_index;
              end
            end
            default: begin
              // unused opcodes: drop the request
            end
          endcase
        end
      end
      FR_LIST: begin
        if (!cmdq_full) begin
          cmd_push       = 1'b1;
          cmd.kind       = deq_pkg::CMD_READ;
          cmd.addr       = deq_pkg::ADDR_W'(list_pos);
          cmd.last       = (list_left == CNT_W'(1));
          list_left_next = list_left - 1'b1;
          list_pos_next  = list_bwd ? ring_dec(list_pos) : ring_inc(list_pos);
          if (list_left == CNT_W'(1)) begin
            state_next = FR_IDLE;
          end
        end
      end
      default: begin
        state_next = FR_IDLE;
      end
    endcase
  end

  // Hold queue bookkeeping and listing state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= FR_IDLE;
      front_index <= '0;
      entry_count <= '0;
      list_left   <= '0;
    end else begin
      state       <= state_next;
      front_index <= front_index_next;
      entry_count <= entry_count_next;
      list_left   <= list_left_next;
    end
  end

  always_ff @(posedge clk) begin
    list_pos <= list_pos_next;
    list_bwd <= list_bwd_next;
  end

endmodule

>>> rtl/deq_back.sv
// ----------------------------------------------------------------------------
// deq_back: entry store and result output
// Executes store commands in order: a registered store access stage, then
// an output register that holds a result until the sink takes it.
// ----------------------------------------------------------------------------
module deq_back #(
  parameter int CAPACITY = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cmd_valid,
  input  deq_pkg::cmd_t               cmd,
  output logic                        cmd_pop,
  output logic                        res_valid,
  input  logic                        res_ready,
  output logic [deq_pkg::DATA_W-1:0]  res_value,
  output deq_pkg::status_t            res_status,
  output logic                        res_last
);

  localparam int IDX_W = $clog2(CAPACITY);

  logic [deq_pkg::DATA_W-1:0]  entry_store [CAPACITY];
  logic [deq_pkg::DATA_W-1:0]  rd_data;
  logic                        s1_valid;
  deq_pkg::cmd_t               s1_cmd;
  logic                        s1_adv;
  logic                        out_free;
  logic [IDX_W-1:0]            addr;

  assign addr     = cmd.addr[IDX_W-1:0];
  assign out_free = !res_valid || res_ready;
  assign s1_adv   = s1_valid && out_free;
  assign cmd_pop  = cmd_valid && (!s1_valid || s1_adv);

  // Access the store as a command issues
  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      if (cmd.kind == deq_pkg::CMD_WRITE) begin
        entry_store[addr] <= cmd.value;
      end
      rd_data <= entry_store[addr];
      s1_cmd  <= cmd;
    end
  end

  // Load the output register
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      res_value  <= (s1_cmd.kind == deq_pkg::CMD_READ) ? rd_data : s1_cmd.value;
      res_status <= s1_cmd.status;
      res_last   <= s1_cmd.last;
    end
  end

  // Track stage occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      s1_valid  <= cmd_pop || (s1_valid && !s1_adv);
      res_valid <= s1_adv || (res_valid && !res_ready);
    end
  end

endmodule

>>> rtl/double_ended_queue.sv
// ----------------------------------------------------------------------------
// double_ended_queue: bounded double-ended queue of signed 32-bit values
// Ring store with front index and entry count; push, pop and listing at
// either end, one status result per push or pop.
// ----------------------------------------------------------------------------
// Push and pop requests are taken one per cycle while no listing is running
// and the command queue has room; each result then passes through the command
// queue, the store access stage and the output register. A listing of n
// entries occupies the request decoder from the cycle that takes it until one
// read per entry of the single-port entry store has been queued; requests are
// held off until the last read of the listing has been queued. Pushes onto a
// full queue return status full, pops or listings of an empty queue status empty,
// both with a zero value. Unused opcodes are taken and produce no result.
module double_ended_queue #(
  parameter int CAPACITY = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [31:0] value
  input  logic [deq_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // [2:0] opcode
  input  logic [deq_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [31:0] item_value
  output logic [deq_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  // [1:0] status
  output logic [deq_pkg::OUT_TUSER_W-1:0]   m_axis_tuser,
  output logic                              m_axis_tlast
);

  logic                        fe_push;
  deq_pkg::cmd_t               fe_cmd;
  logic                        q_full;
  logic                        q_pop;
  logic                        q_valid;
  deq_pkg::cmd_t               q_cmd;
  logic [deq_pkg::DATA_W-1:0]  res_value;
  deq_pkg::status_t            res_status;

  deq_front #(.CAPACITY(CAPACITY)) u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (s_axis_tvalid),
    .req_ready (s_axis_tready),
    .opcode    (s_axis_tuser),
    .value     (s_axis_tdata),
    .cmd_push  (fe_push),
    .cmd       (fe_cmd),
    .cmdq_full (q_full)
  );

  deq_cmdq u_cmdq (
    .clk        (clk),
    .rst        (rst),
    .push       (fe_push),
    .push_cmd   (fe_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_cmd   (q_cmd)
  );

  deq_back #(.CAPACITY(CAPACITY)) u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (q_valid),
    .cmd        (q_cmd),
    .cmd_pop    (q_pop),
    .res_valid  (m_axis_tvalid),
    .res_ready  (m_axis_tready),
    .res_value  (res_value),
    .res_status (res_status),
    .res_last   (m_axis_tlast)
  );

  // Drive the result payload and its status sideband
  assign m_axis_tdata = res_value;
  assign m_axis_tuser = res_status;

endmodule

>>> rtl/deq_checker.sv
// ----------------------------------------------------------------------------
// deq_checker: port-level checks of the double-ended queue
// Watches the result stream for held results and consistent status codes.
// ----------------------------------------------------------------------------
module deq_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [deq_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input logic [deq_pkg::OUT_TUSER_W-1:0]  m_axis_tuser,
  input logic                             m_axis_tlast
);

  // Keep a stalled result pending
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // Hold a stalled result unchanged
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // Only defined status codes leave the block
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser == deq_pkg::ST_OK ||
                       m_axis_tuser == deq_pkg::ST_EMPTY ||
                       m_axis_tuser == deq_pkg::ST_FULL))
    else $error("undefined status code");

  // An empty or full status ends its request with a zero value
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser != deq_pkg::ST_OK |->
      m_axis_tlast && m_axis_tdata == '0)
    else $error("error status with value or without last");

endmodule

bind double_ended_queue deq_checker u_deq_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the double-ended queue
// Drives push, pop and listing requests over the input stream with random
// gaps, tracks the ring contents in a local model of the queue, and checks
// every result on the output stream field by field, in order.
// ----------------------------------------------------------------------------
module tb;

  localparam int CAP          = deq_pkg::MAX_CAPACITY;
  localparam int N_RANDOM     = 245;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 16;
  localparam int IDLE_PCT     = 15;

  // Opcodes the block ignores
  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  // Request fields: value on tdata, opcode on tuser
  typedef struct packed {
    logic [deq_pkg::DATA_W-1:0] value;
    logic [2:0]                 op;
  } deq_request_t;

  typedef struct packed {
    logic [deq_pkg::DATA_W-1:0] item_value;
    deq_pkg::status_t           status;
    logic                       last;
  } deq_result_t;

  logic                            clk           = 1'b0;
  logic                            rst           = 1'b1;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  // [31:0] value
  logic [deq_pkg::IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  // [2:0] opcode
  logic [deq_pkg::IN_TUSER_W-1:0]  s_axis_tuser  = '0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  // [31:0] item_value
  logic [deq_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  // [1:0] status
  logic [deq_pkg::OUT_TUSER_W-1:0] m_axis_tuser;
  logic                            m_axis_tlast;

  deq_request_t request_backlog[$];
  deq_result_t  due_results[$];

  // Local copy of the ring
  logic [deq_pkg::DATA_W-1:0] slots [CAP];
  int unsigned       front_ptr    = 0;
  int unsigned       depth_now    = 0;

  // Queue depth as seen by the stimulus generator
  int unsigned       shadow_depth = 0;

  int unsigned       req_accepted = 0;
  int unsigned       mismatches   = 0;
  int unsigned       quiet_cycles = 0;
  logic              req_taken    = 1'b0;
  bit                steady;

  double_ended_queue #(
    .CAPACITY(CAP)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // No idling on either side over a middle stretch of requests
  assign steady = (req_accepted >= 100) && (req_accepted < 170);

  // Apply one accepted request to the ring and queue the results it causes
  task automatic apply_request(input deq_request_t req);
    int unsigned pos;
    int unsigned idx;
    case (req.op)
      deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_PUSH_BACK: begin
        if (depth_now >= CAP) begin
          due_results.push_back(deq_result_t'{'0, deq_pkg::ST_FULL, 1'b1});
        end else begin
          if (req.op == deq_pkg::OP_PUSH_FRONT) begin
            front_ptr = (front_ptr + CAP - 1) % CAP;
            pos = front_ptr;
          end else begin
            pos = (front_ptr + depth_now) % CAP;
          end
          slots[pos] = req.value;
          depth_now++;
          due_results.push_back(deq_result_t'{req.value, deq_pkg::ST_OK, 1'b1});
        end
      end
      deq_pkg::OP_POP_FRONT, deq_pkg::OP_POP_BACK: begin
        if (depth_now == 0) begin
          due_results.push_back(deq_result_t'{'0, deq_pkg::ST_EMPTY, 1'b1});
        end else begin
          if (req.op == deq_pkg::OP_POP_FRONT) begin
            pos = front_ptr;
            front_ptr = (front_ptr + 1) % CAP;
          end else begin
            pos = (front_ptr + depth_now - 1) % CAP;
          end
          depth_now--;
          due_results.push_back(deq_result_t'{slots[pos], deq_pkg::ST_OK, 1'b1});
        end
      end
      deq_pkg::OP_LIST_FWD, deq_pkg::OP_LIST_BWD: begin
        if (depth_now == 0) begin
          due_results.push_back(deq_result_t'{'0, deq_pkg::ST_EMPTY, 1'b1});
        end else begin
          for (int unsigned k = 0; k < depth_now; k++) begin
            idx = (req.op == deq_pkg::OP_LIST_FWD) ? k : depth_now - 1 - k;
            pos = (front_ptr + idx) % CAP;
            due_results.push_back(deq_result_t'{slots[pos], deq_pkg::ST_OK,
                                                k + 1 == depth_now});
          end
        end
      end
      default: begin
        // unused opcodes: dropped without a result
      end
    endcase
  endtask

  // Queue one request for the driver and track the depth it leaves behind
  task automatic queue_request(input logic [2:0] op,
                               input logic [deq_pkg::DATA_W-1:0] value);
    request_backlog.push_back(deq_request_t'{value, op});
    case (op)
      deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_PUSH_BACK:
        if (shadow_depth < CAP) shadow_depth++;
      deq_pkg::OP_POP_FRONT, deq_pkg::OP_POP_BACK:
        if (shadow_depth > 0) shadow_depth--;
      default: ;
    endcase
  endtask

  // Sample both handshakes, predict on requests, check results
  always @(posedge clk) begin : monitor
    deq_result_t got;
    deq_result_t want;
    req_taken <= !rst && s_axis_tvalid && s_axis_tready;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        apply_request(deq_request_t'{s_axis_tdata, s_axis_tuser});
        req_accepted++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.item_value = m_axis_tdata;
        got.status     = deq_pkg::status_t'(m_axis_tuser);
        got.last       = m_axis_tlast;
        if (due_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: value %h status %0d last %0b",
                     got.item_value, got.status, got.last);
        end else begin
          want = due_results.pop_front();
          if (got.item_value !== want.item_value || got.status !== want.status ||
              got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: expected %h/%0d/%0b, got %h/%0d/%0b",
                       want.item_value, want.status, want.last,
                       got.item_value, got.status, got.last);
          end
        end
      end
    end
  end

  // Present requests from the backlog and toggle the result-side ready
  always @(negedge clk) begin : driver
    deq_request_t head;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      m_axis_tready <= 1'b0;
    end else begin
      if (req_taken) void'(request_backlog.pop_front());
      if (s_axis_tvalid && !req_taken) begin
        // hold the current request until it is taken
      end else if (request_backlog.size() != 0 &&
                   (steady || $urandom_range(99) >= IDLE_PCT)) begin
        head = request_backlog[0];
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= head.value;
        s_axis_tuser  <= head.op;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
      m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Build the stimulus, release reset, wait for the queue to drain
  initial begin : stimulus
    int unsigned                counted;
    int unsigned                roll;
    bit                         filling;
    logic [2:0]                 op;
    logic [deq_pkg::DATA_W-1:0] val;

    // Empty queue at both ends and for both listings
    queue_request(deq_pkg::OP_POP_FRONT, 32'h1234_5678);
    queue_request(deq_pkg::OP_POP_BACK, '0);
    queue_request(deq_pkg::OP_LIST_FWD, '0);
    queue_request(deq_pkg::OP_LIST_BWD, 32'hFFFF_FFFF);
    // Extreme values; the first push front wraps the front index
    queue_request(deq_pkg::OP_PUSH_FRONT, 32'h8000_0000);
    queue_request(deq_pkg::OP_PUSH_BACK, 32'h7FFF_FFFF);
    queue_request(deq_pkg::OP_PUSH_FRONT, 32'h0000_0000);
    queue_request(deq_pkg::OP_PUSH_BACK, 32'hFFFF_FFFF);
    queue_request(deq_pkg::OP_LIST_FWD, '0);
    queue_request(deq_pkg::OP_LIST_BWD, '0);
    // Unused opcodes leave the queue alone
    queue_request(OP_SPARE_LO, 32'hA5A5_A5A5);
    queue_request(OP_SPARE_HI, 32'h5A5A_5A5A);
    queue_request(deq_pkg::OP_POP_FRONT, '0);
    queue_request(deq_pkg::OP_POP_BACK, '0);
    queue_request(deq_pkg::OP_LIST_FWD, '0);
    queue_request(deq_pkg::OP_POP_BACK, '0);
    queue_request(deq_pkg::OP_POP_FRONT, '0);
    queue_request(deq_pkg::OP_POP_FRONT, '0);
    queue_request(deq_pkg::OP_LIST_BWD, '0);

    // Random phases that fill the queue to full and drain it to empty
    counted = 0;
    filling = 1'b1;
    while (counted < N_RANDOM) begin
      if (filling && shadow_depth == CAP && $urandom_range(3) == 0) filling = 1'b0;
      if (!filling && shadow_depth == 0 && $urandom_range(3) == 0) filling = 1'b1;
      case ($urandom_range(7))
        0:       val = 32'h8000_0000;
        1:       val = 32'h7FFF_FFFF;
        2:       val = 32'h0000_0000;
        3:       val = 32'hFFFF_FFFF;
        default: val = $urandom;
      endcase
      roll = $urandom_range(99);
      if (roll < 3) begin
        op = $urandom_range(1) ? OP_SPARE_LO : OP_SPARE_HI;
      end else begin
        counted++;
        if (roll < 10)
          op = $urandom_range(1) ? deq_pkg::OP_LIST_FWD : deq_pkg::OP_LIST_BWD;
        else if ((roll < 22) != filling)
          op = $urandom_range(1) ? deq_pkg::OP_PUSH_FRONT : deq_pkg::OP_PUSH_BACK;
        else
          op = $urandom_range(1) ? deq_pkg::OP_POP_FRONT : deq_pkg::OP_POP_BACK;
      end
      queue_request(op, val);
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (request_backlog.size() != 0 || s_axis_tvalid) @(negedge clk);
    while (due_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatches == 0 && due_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> double_ended_queue.f
rtl/deq_pkg.sv
rtl/deq_cmdq.sv
rtl/deq_front.sv
rtl/deq_back.sv
rtl/double_ended_queue.sv
rtl/deq_checker.sv
tb/sv/tb.sv
